// ===== rtl/dpc_pkg.sv =====
// ============================================================================
// dpc_pkg: shared types and constants of the deck playback clock
// Command codes, sequencer states, shared-unit geometry and a saturation helper.
// ============================================================================
package dpc_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    // field widths
    localparam int TIME_W  = 40;
    localparam int POS_W   = 40;
    localparam int RATE_W  = 24;
    localparam int BPM_W   = 16;
    localparam int BEATS_W = 16;
    localparam int SRC_W   = 2;
    localparam int DUR_W   = 32;
    localparam int SHOWN_W = 32;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    // shared unit geometry
    localparam int LO_W     = 48;   // dividend / multiplier register
    localparam int HI_W     = 42;   // remainder / accumulator register
    localparam int OPB_W    = 41;   // divisor / multiplicand
    localparam int MUL_STEPS = RATE_W;
    localparam int DIV_STEPS = LO_W;
    localparam int CNT_W    = $clog2(DIV_STEPS + 1);
    localparam int PROD_W   = HI_W + MUL_STEPS;

    localparam logic signed [POS_W-1:0]  POS_MAX  = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0]  POS_MIN  = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
    localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_SEEK     = 3'd0,
        OP_RATE     = 3'd1,
        OP_BEATS    = 3'd2,
        OP_BPM      = 3'd3,
        OP_SOURCE   = 3'd4,
        OP_READ     = 3'd5,
        OP_RESOLVE  = 3'd6,
        OP_TAKEOVER = 3'd7
    } dpc_op_t;

    localparam logic [SRC_W-1:0] SRC_TIMECODE = 2'd0;
    localparam logic [SRC_W-1:0] SRC_FREE     = 2'd1;
    localparam logic [SRC_W-1:0] SRC_TEMPO    = 2'd2;

    localparam logic [1:0] MODE_LOOP     = 2'd0;
    localparam logic [1:0] MODE_ONCE     = 2'd1;
    localparam logic [1:0] MODE_PINGPONG = 2'd2;

    localparam logic [1:0] POL_GRAB   = 2'd0;
    localparam logic [1:0] POL_JUMP   = 2'd1;
    localparam logic [1:0] POL_IGNORE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_TSTART,
        ST_TWAIT,
        ST_MSTART,
        ST_MWAIT,
        ST_APPLY,
        ST_FWAIT,
        ST_OUT
    } dpc_state_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } dpc_alu_cmd_t;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [67:0] v);
        if (v > 68'(POS_MAX)) begin
            sat_pos = POS_MAX;
        end else if (v < 68'(POS_MIN)) begin
            sat_pos = POS_MIN;
        end else begin
            sat_pos = v[POS_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/deck_playback_clock.sv =====
// ============================================================================
// deck_playback_clock: timestamped playback clock of one clip deck
// Keeps origin, rate, tempo and source state; answers read-source and resolve.
// ============================================================================
// Usage:
//   s_t* carries one command request: tuser holds the operation code, tdata
//   the time, position, rate, bpm, beats and source fields. Only read-source
//   and resolve produce a request on m_t* (folded or source position, rate,
//   reversed and finished flags); all other commands only update state.
//   The cfg_* port writes clip duration, play mode and takeover policy; the
//   user is to write it only while the block is idle, which the block leaves unchecked.
// Flow and sharing:
//   s_tready is high only in the idle state; one command is handled at a time.
//   Seek, set source and takeover finish in the dispatch state. Platter read
//   and once/zero resolve go from dispatch to output; loop/ping-pong resolve
//   first waits on a 48-step divide. Timeline commands run a 24-step multiply,
//   under tempo lock after a 48-step divide for the stretched rate. Divides and
//   multiplies run through the one shared add/subtract unit in dpc_alu.
// Reset: aresetn is synchronous, active low; state returns to rate one,
//   timecode source, zero origin; registers to 65536, loop, grab.
// Stall: a finished result waits in the res_* registers; the block holds in
//   its output state until m_tready takes the previous request.
// ============================================================================
module deck_playback_clock
    import dpc_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // command channel
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // tdata: time_now[39:0], position_value[79:40], rate_value[103:80],
    //        bpm_value[119:104], beats_value[135:120], source_select[137:136]
    input  logic [143:0]         s_tdata,
    // tuser: operation[2:0]
    input  logic [2:0]           s_tuser,
    // result channel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // tdata: out_position[39:0], out_rate[63:40], is_reversed[64],
    //        is_finished[65], zero pad above
    output logic [71:0]          m_tdata,
    // configuration writes
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

    localparam logic signed [RATE_W-1:0] RATE_ONE = RATE_W'(64'd1 << FRACTION_BITS);

    dpc_state_t state_reg, state_next;

    // configuration
    logic [DUR_W-1:0] dur_reg;
    logic [1:0]       mode_reg;
    logic [1:0]       policy_reg;

    // latched command
    logic [2:0]               in_op_reg;
    logic [TIME_W-1:0]        in_time_reg;
    logic signed [POS_W-1:0]  in_pos_reg;
    logic signed [RATE_W-1:0] in_rate_reg;
    logic [BPM_W-1:0]         in_bpm_reg;
    logic [BEATS_W-1:0]       in_beats_reg;
    logic [SRC_W-1:0]         in_src_reg;

    // clock state
    logic [TIME_W-1:0]        origin_time_reg;
    logic signed [POS_W-1:0]  origin_pos_reg;
    logic signed [RATE_W-1:0] cmd_rate_reg;
    logic [BPM_W-1:0]         bpm_reg;
    logic [BEATS_W-1:0]       beats_reg;
    logic [SRC_W-1:0]         src_reg;
    logic signed [POS_W-1:0]  offset_reg;
    logic [SHOWN_W-1:0]       shown_reg;

    // working registers
    logic signed [RATE_W-1:0] speed_reg;
    logic [LO_W-1:0]          num_reg;
    logic [BEATS_W+3:0]       den_reg;
    logic signed [POS_W-1:0]  tl_reg;
    logic [POS_W-1:0]         res_pos_reg;
    logic [RATE_W-1:0]        res_rate_reg;
    logic                     res_rev_reg;
    logic                     res_fin_reg;

    logic        m_tvalid_reg;
    logic [71:0] m_tdata_reg;

    // shared unit
    dpc_alu_cmd_t     alu_cmd;
    logic [LO_W-1:0]  alu_opa;
    logic [OPB_W-1:0] alu_opb;
    logic             alu_busy;
    logic [HI_W-1:0]  alu_hi;
    logic [LO_W-1:0]  alu_lo;

    dpc_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (alu_cmd),
        .opa     (alu_opa),
        .opb     (alu_opb),
        .busy    (alu_busy),
        .hi      (alu_hi),
        .lo      (alu_lo)
    );

    // ---------------------------------------------------------------- datapath
    logic tempo_on;
    logic timeline_op;
    logic out_free;

    logic signed [TIME_W:0] dt;
    logic [TIME_W:0]        dt_mag;
    logic [RATE_W-1:0]      spd_mag;
    logic                   tl_neg;
    logic [PROD_W-1:0]      prod;
    logic [PROD_W-1:0]      prod_sh;
    logic signed [67:0]     delta;
    logic signed [67:0]     tl_sum;

    logic [RATE_W-1:0]      q_mag;
    logic signed [RATE_W-1:0] tempo_speed;

    logic                   pos_neg;
    logic [POS_W-1:0]       pos_mag;
    logic [DUR_W:0]         span;
    logic [DUR_W:0]         rem;
    logic [DUR_W:0]         wrapped;
    logic [DUR_W:0]         pp_back;
    logic signed [RATE_W-1:0] rate_negated;

    logic signed [POS_W-1:0] platter_pos;
    logic signed [POS_W-1:0] grab_offset;

    logic [POS_W-1:0]  once_pos;
    logic              once_fin;

    always_comb begin
        tempo_on = (src_reg == SRC_TEMPO) && (bpm_reg != '0) && (beats_reg != '0)
                   && (dur_reg != '0);
        timeline_op = (in_op_reg == OP_RATE) || (in_op_reg == OP_BEATS)
                      || (in_op_reg == OP_BPM)
                      || ((in_op_reg == OP_READ) && (src_reg != SRC_TIMECODE));
        out_free = !m_tvalid_reg || m_tready;

        // timeline: origin + rate * (t - origin_time) >> FRACTION_BITS
        dt      = $signed({1'b0, in_time_reg}) - $signed({1'b0, origin_time_reg});
        dt_mag  = dt[TIME_W] ? (TIME_W+1)'(-dt) : (TIME_W+1)'(dt);
        spd_mag = speed_reg[RATE_W-1] ? RATE_W'(-speed_reg) : RATE_W'(speed_reg);
        tl_neg  = speed_reg[RATE_W-1] ^ dt[TIME_W];
        prod    = {alu_hi, alu_lo[LO_W-1 -: MUL_STEPS]};
        prod_sh = prod >> FRACTION_BITS;
        delta   = tl_neg ? -$signed(68'(prod_sh)) : $signed(68'(prod_sh));
        tl_sum  = 68'(origin_pos_reg) + delta;

        // tempo-locked rate from the quotient, clipped, sign of commanded rate
        if (cmd_rate_reg[RATE_W-1]) begin
            q_mag       = (alu_lo > LO_W'(24'h800000)) ? 24'h800000 : alu_lo[RATE_W-1:0];
            tempo_speed = -$signed(q_mag);
        end else begin
            q_mag       = (alu_lo > LO_W'(RATE_MAX)) ? RATE_MAX : alu_lo[RATE_W-1:0];
            tempo_speed = $signed(q_mag);
        end

        // fold: remainder of |pos| by span, moved to the floored sense
        pos_neg = in_pos_reg[POS_W-1];
        pos_mag = pos_neg ? POS_W'(-in_pos_reg) : POS_W'(in_pos_reg);
        span    = (mode_reg == MODE_PINGPONG) ? {dur_reg, 1'b0} : {1'b0, dur_reg};
        rem     = alu_hi[DUR_W:0];
        if (rem == '0) begin
            wrapped = '0;
        end else if (pos_neg) begin
            wrapped = span - rem;
        end else begin
            wrapped = rem;
        end
        pp_back = span - wrapped;
        rate_negated = (in_rate_reg == RATE_MIN) ? RATE_MAX : -in_rate_reg;

        // once mode parks at the ends
        if (pos_neg) begin
            once_pos = '0;
            once_fin = 1'b1;
        end else if (in_pos_reg >= $signed({8'b0, dur_reg})) begin
            once_pos = {8'b0, dur_reg};
            once_fin = 1'b1;
        end else begin
            once_pos = in_pos_reg;
            once_fin = 1'b0;
        end

        platter_pos = sat_pos(68'(in_pos_reg) + 68'(offset_reg));
        grab_offset = sat_pos($signed({36'b0, shown_reg}) - 68'(in_pos_reg));
    end

    // ----------------------------------------------------------- next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_DISPATCH;
            end
            ST_DISPATCH: begin
                if (timeline_op) begin
                    state_next = tempo_on ? ST_TSTART : ST_MSTART;
                end else if (in_op_reg == OP_READ) begin
                    state_next = ST_OUT;
                end else if (in_op_reg == OP_RESOLVE) begin
                    if (dur_reg == '0 || mode_reg == MODE_ONCE) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_FWAIT;
                    end
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_TSTART: state_next = ST_TWAIT;
            ST_TWAIT: begin
                if (!alu_busy) state_next = ST_MSTART;
            end
            ST_MSTART: state_next = ST_MWAIT;
            ST_MWAIT: begin
                if (!alu_busy) state_next = ST_APPLY;
            end
            ST_APPLY: begin
                state_next = (in_op_reg == OP_READ) ? ST_OUT : ST_IDLE;
            end
            ST_FWAIT: begin
                if (!alu_busy) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // -------------------------------------------------------------- outputs
    always_comb begin
        alu_cmd = '0;
        alu_opa = '0;
        alu_opb = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_DISPATCH: begin
                // loop / ping-pong wrap divide starts right away
                if (!timeline_op && in_op_reg == OP_RESOLVE && dur_reg != '0
                    && mode_reg != MODE_ONCE) begin
                    alu_cmd.start  = 1'b1;
                    alu_cmd.is_div = 1'b1;
                    alu_opa = LO_W'(pos_mag);
                    alu_opb = OPB_W'(span);
                end
            end
            ST_TSTART: begin
                alu_cmd.start  = 1'b1;
                alu_cmd.is_div = 1'b1;
                alu_opa = num_reg;
                alu_opb = OPB_W'(den_reg);
            end
            ST_MSTART: begin
                alu_cmd.start  = 1'b1;
                alu_cmd.is_div = 1'b0;
                alu_opa = LO_W'(spd_mag);
                alu_opb = OPB_W'(dt_mag);
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------ registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            dur_reg         <= DUR_W'(32'd65536);
            mode_reg        <= MODE_LOOP;
            policy_reg      <= POL_GRAB;
            origin_time_reg <= '0;
            origin_pos_reg  <= '0;
            cmd_rate_reg    <= RATE_ONE;
            bpm_reg         <= '0;
            beats_reg       <= '0;
            src_reg         <= SRC_TIMECODE;
            offset_reg      <= '0;
            shown_reg       <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_DURATION: dur_reg    <= cfg_wr_data[DUR_W-1:0];
                    CFG_MODE:     mode_reg   <= cfg_wr_data[1:0];
                    CFG_POLICY:   policy_reg <= cfg_wr_data[1:0];
                    default: ;
                endcase
            end

            // a new result loads when the slot is free, else a taken one drops
            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_DISPATCH: begin
                    case (in_op_reg)
                        OP_SEEK: begin
                            origin_pos_reg  <= in_pos_reg;
                            origin_time_reg <= in_time_reg;
                        end
                        OP_SOURCE: begin
                            if (in_src_reg <= SRC_TEMPO && in_src_reg != src_reg) begin
                                if (in_src_reg != SRC_TIMECODE) begin
                                    origin_pos_reg  <= $signed({8'b0, shown_reg});
                                    origin_time_reg <= in_time_reg;
                                end
                                src_reg <= in_src_reg;
                            end
                        end
                        OP_TAKEOVER: begin
                            if (policy_reg != POL_IGNORE) begin
                                offset_reg <= (policy_reg == POL_JUMP) ? '0 : grab_offset;
                                src_reg    <= SRC_TIMECODE;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_APPLY: begin
                    case (in_op_reg)
                        OP_RATE: begin
                            origin_pos_reg  <= tl_reg;
                            origin_time_reg <= in_time_reg;
                            cmd_rate_reg    <= in_rate_reg;
                        end
                        OP_BEATS: begin
                            origin_pos_reg  <= tl_reg;
                            origin_time_reg <= in_time_reg;
                            beats_reg       <= in_beats_reg;
                        end
                        OP_BPM: begin
                            origin_pos_reg  <= tl_reg;
                            origin_time_reg <= in_time_reg;
                            bpm_reg         <= in_bpm_reg;
                        end
                        default: ;
                    endcase
                end
                ST_OUT: begin
                    if (out_free && in_op_reg == OP_RESOLVE) begin
                        shown_reg <= res_pos_reg[SHOWN_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            in_op_reg    <= s_tuser;
            in_time_reg  <= s_tdata[39:0];
            in_pos_reg   <= s_tdata[79:40];
            in_rate_reg  <= s_tdata[103:80];
            in_bpm_reg   <= s_tdata[119:104];
            in_beats_reg <= s_tdata[135:120];
            in_src_reg   <= s_tdata[137:136];
        end

        case (state_reg)
            ST_DISPATCH: begin
                speed_reg <= cmd_rate_reg;
                num_reg   <= dur_reg * bpm_reg;
                den_reg   <= {beats_reg, 4'b0} - (BEATS_W+4)'(beats_reg);
                res_rev_reg <= 1'b0;
                if (in_op_reg == OP_READ) begin
                    res_pos_reg  <= platter_pos;
                    res_rate_reg <= in_rate_reg;
                    res_fin_reg  <= 1'b0;
                end else if (dur_reg == '0) begin
                    res_pos_reg  <= '0;
                    res_rate_reg <= in_rate_reg;
                    res_fin_reg  <= 1'b0;
                end else begin
                    res_pos_reg  <= once_pos;
                    res_fin_reg  <= once_fin;
                    res_rate_reg <= once_fin ? '0 : in_rate_reg;
                end
            end
            ST_TWAIT: begin
                if (!alu_busy) speed_reg <= tempo_speed;
            end
            ST_MWAIT: begin
                if (!alu_busy) tl_reg <= sat_pos(tl_sum);
            end
            ST_APPLY: begin
                res_pos_reg  <= tl_reg;
                res_rate_reg <= speed_reg;
                res_rev_reg  <= 1'b0;
                res_fin_reg  <= 1'b0;
            end
            ST_FWAIT: begin
                if (!alu_busy) begin
                    res_fin_reg <= 1'b0;
                    if (mode_reg == MODE_PINGPONG && wrapped > {1'b0, dur_reg}) begin
                        res_pos_reg  <= POS_W'(pp_back);
                        res_rev_reg  <= 1'b1;
                        res_rate_reg <= rate_negated;
                    end else begin
                        res_pos_reg  <= POS_W'(wrapped);
                        res_rev_reg  <= 1'b0;
                        res_rate_reg <= in_rate_reg;
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tdata_reg <= {6'b0, res_fin_reg, res_rev_reg, res_rate_reg, res_pos_reg};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== rtl/dpc_alu.sv =====
// ============================================================================
// dpc_alu: shared shift-add multiplier and restoring divider
// One adder/subtractor, one bit per cycle; product in {hi, lo[top]}, quotient
// in lo, remainder in hi.
// ============================================================================
module dpc_alu
    import dpc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  dpc_alu_cmd_t      cmd,
    input  logic [LO_W-1:0]   opa,      // dividend or multiplier
    input  logic [OPB_W-1:0]  opb,      // divisor or multiplicand
    output logic              busy,
    output logic [HI_W-1:0]   hi,
    output logic [LO_W-1:0]   lo
);

    logic [HI_W-1:0]  hi_reg,  hi_next;
    logic [LO_W-1:0]  lo_reg,  lo_next;
    logic [OPB_W-1:0] opb_reg;
    logic             div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;

    logic [HI_W-1:0] shifted;
    logic [HI_W-1:0] add_a;
    logic [HI_W-1:0] add_b;
    logic [HI_W:0]   sum;
    logic [HI_W:0]   mstep;

    always_comb begin
        shifted = {hi_reg[HI_W-2:0], lo_reg[LO_W-1]};
        add_a   = div_reg ? shifted : hi_reg;
        add_b   = div_reg ? ~{1'b0, opb_reg} : {1'b0, opb_reg};
        sum     = {1'b0, add_a} + {1'b0, add_b} + (HI_W+1)'(div_reg);
        mstep   = lo_reg[0] ? sum : {1'b0, hi_reg};
        if (div_reg) begin
            // carry out means no borrow: quotient bit is one
            hi_next = sum[HI_W] ? sum[HI_W-1:0] : shifted;
            lo_next = {lo_reg[LO_W-2:0], sum[HI_W]};
        end else begin
            hi_next = mstep[HI_W:1];
            lo_next = {mstep[0], lo_reg[LO_W-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (cmd.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= cmd.is_div ? CNT_W'(DIV_STEPS) : CNT_W'(MUL_STEPS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            hi_reg  <= '0;
            lo_reg  <= opa;
            opb_reg <= opb;
            div_reg <= cmd.is_div;
        end else if (busy_reg) begin
            hi_reg <= hi_next;
            lo_reg <= lo_next;
        end
    end

    assign busy = busy_reg;
    assign hi   = hi_reg;
    assign lo   = lo_reg;

endmodule
